[hdl/mrf_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response framer package
// Shared types, register defaults and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam int BYTE_W    = 8;
    localparam int CRC_W     = 16;
    localparam int CFG_IDX_W = 8;

    localparam logic [BYTE_W-1:0] EXC_BIT   = 8'h80;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;

    localparam logic [BYTE_W-1:0] SLAVE_ADDRESS_RST  = 8'd1;
    localparam logic [BYTE_W-1:0] READ_FUNCTION_RST  = 8'd3;
    localparam logic [BYTE_W-1:0] WRITE_FUNCTION_RST = 8'd6;
    localparam logic              WRITE_MODE_RST     = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDRESS  = 8'd0,
        CFG_READ_FUNCTION  = 8'd1,
        CFG_WRITE_FUNCTION = 8'd2,
        CFG_WRITE_MODE     = 8'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_FUNC   = 3'd1,
        PH_LEN    = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC_LO = 3'd4,
        PH_CRC_HI = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CRC_ERR   = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_EXCEPTION = 2'd3
    } status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] slave_address;
        logic [BYTE_W-1:0] read_function;
        logic [BYTE_W-1:0] write_function;
        logic              write_mode;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] byte_index;
        status_t           status;
        logic              was_write;
    } res_t;

    // Reflected CRC-16 (poly 0xA001), one byte unrolled over eight bit steps
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[hdl/mrf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Holds slave address, function codes and mode; writes to unknown indices drop.
// ----------------------------------------------------------------------------
module mrf_cfg_regs
    import mrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [BYTE_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_SLAVE_ADDRESS:  cfg_next.slave_address  = wr_data;
                CFG_READ_FUNCTION:  cfg_next.read_function  = wr_data;
                CFG_WRITE_FUNCTION: cfg_next.write_function = wr_data;
                CFG_WRITE_MODE:     cfg_next.write_mode     = wr_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address  <= SLAVE_ADDRESS_RST;
            cfg_reg.read_function  <= READ_FUNCTION_RST;
            cfg_reg.write_function <= WRITE_FUNCTION_RST;
            cfg_reg.write_mode     <= WRITE_MODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/mrf_frame_core.sv]
// ----------------------------------------------------------------------------
// Frame core
// Frame state, length counters, running CRC; one received word per step cycle
// ----------------------------------------------------------------------------
module mrf_frame_core
    import mrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  cfg_t              cfg,
    output logic              has_result,
    output res_t              res
);

    phase_t            phase_reg,  phase_next;
    logic [BYTE_W-1:0] len_reg,    len_next;
    logic [BYTE_W-1:0] seen_reg,   seen_next;
    logic [CRC_W-1:0]  crc_reg,    crc_next;
    logic [BYTE_W-1:0] crc_lo_reg, crc_lo_next;

    logic [BYTE_W-1:0] seen_inc;
    logic [CRC_W-1:0]  crc_with_byte;

    assign seen_inc      = seen_reg + 8'd1;
    assign crc_with_byte = crc_update(crc_reg, rx_byte);

    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        seen_next   = seen_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        has_result  = 1'b0;
        res         = '0;
        if (step)
        begin
            unique case (phase_reg)
                PH_FUNC:
                begin
                    phase_next = PH_HUNT;
                    if (cfg.write_mode)
                    begin
                        has_result    = 1'b1;
                        res.kind      = KIND_STATUS;
                        res.data_byte = rx_byte;
                        res.was_write = 1'b1;
                        if (rx_byte == cfg.write_function)
                            res.status = ST_OK;
                        else if (rx_byte == (cfg.write_function | EXC_BIT))
                            res.status = ST_EXCEPTION;
                        else
                            res.status = ST_MISMATCH;
                    end
                    else if (rx_byte == cfg.read_function)
                    begin
                        crc_next   = crc_with_byte;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        has_result    = 1'b1;
                        res.kind      = KIND_STATUS;
                        res.data_byte = rx_byte;
                        res.status    = (rx_byte == (cfg.read_function | EXC_BIT))
                                        ? ST_EXCEPTION : ST_MISMATCH;
                    end
                end
                PH_LEN:
                begin
                    crc_next   = crc_with_byte;
                    len_next   = rx_byte;
                    seen_next  = '0;
                    phase_next = (rx_byte == '0) ? PH_CRC_LO : PH_DATA;
                end
                PH_DATA:
                begin
                    has_result     = 1'b1;
                    res.kind       = KIND_DATA;
                    res.data_byte  = rx_byte;
                    res.byte_index = seen_reg;
                    crc_next       = crc_with_byte;
                    seen_next      = seen_inc;
                    if (seen_inc == len_reg)
                        phase_next = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = rx_byte;
                    phase_next  = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    has_result    = 1'b1;
                    res.kind      = KIND_STATUS;
                    res.data_byte = cfg.read_function;
                    res.status    = ({rx_byte, crc_lo_reg} == crc_reg) ? ST_OK : ST_CRC_ERR;
                    phase_next    = PH_HUNT;
                end
                default:
                begin
                    // hunt: drop anything that is not our address
                    phase_next = PH_HUNT;
                    if (rx_byte == cfg.slave_address)
                    begin
                        crc_next   = crc_update(CRC_INIT, rx_byte);
                        phase_next = PH_FUNC;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            len_reg    <= '0;
            seen_reg   <= '0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            seen_reg   <= seen_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    // payload counter stays below the announced length while in the payload
    a_seen_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> seen_reg < len_reg)
        else $error("payload counter reached length inside payload phase");

    // a zero length byte skips straight to the CRC
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_LEN && rx_byte == '0 |=> phase_reg == PH_CRC_LO)
        else $error("zero length frame did not go to CRC phase");

    // only function, payload and CRC-high words produce a result
    a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        has_result |-> (phase_reg == PH_FUNC || phase_reg == PH_DATA ||
                        phase_reg == PH_CRC_HI))
        else $error("result produced in a silent phase");

endmodule

[hdl/mrf_out_buf.sv]
// ----------------------------------------------------------------------------
// Output skid buffer
// Two-entry result register so input stays open while a result waits.
// ----------------------------------------------------------------------------
module mrf_out_buf
    import mrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_res,
    output logic can_push,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t main_reg, main_next;
    res_t skid_reg, skid_next;
    logic pop;

    assign pop      = main_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // advance skid into main once main drains
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    // skid only ever holds a word behind a full main register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty main register");

    // a word taken from main with skid full is replaced by the skid word
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> main_valid_reg && !skid_valid_reg &&
                                  main_reg == $past(skid_reg))
        else $error("skid word lost on drain");

endmodule

[hdl/modbus_rtu_response_framer.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response framer
// Byte-serial response receiver with address hunt and CRC-16 check.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle while in_ready is high; each result
// word is registered in the output buffer. Bytes are checked against the
// slave address, function code, length and CRC by the frame core, which keeps
// the running CRC and updates it one byte per cycle while input is accepted;
// payload bytes pass out as they arrive and a status word closes each frame. A
// two-entry output register lets input continue for one further result while
// the output is stalled. Configuration words are taken in any cycle
// (cfg_ready is always high) and should be written while the block is idle.
module modbus_rtu_response_framer
    import mrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 kind,
    output logic [BYTE_W-1:0]    data_byte,
    output logic [BYTE_W-1:0]    byte_index,
    output logic [1:0]           status,
    output logic                 was_write
);

    cfg_t cfg;
    res_t core_res;
    res_t out_res;
    logic core_has_result;
    logic step;
    logic can_push;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_push;
    assign step      = in_valid && can_push;

    mrf_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    mrf_frame_core u_frame_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (rx_byte),
        .cfg        (cfg),
        .has_result (core_has_result),
        .res        (core_res)
    );

    mrf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_has_result),
        .push_res  (core_res),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind       = out_res.kind;
    assign data_byte  = out_res.data_byte;
    assign byte_index = out_res.byte_index;
    assign status     = out_res.status;
    assign was_write  = out_res.was_write;

endmodule

[tb/sv/tb_modbus_rtu_response_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response framer testbench
// Feeds whole, broken and noisy response frames under random flow control,
// with several register settings, and checks every output word against a
// byte-level model of the framer kept inside the bench.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_framer;
    import mrf_pkg::*;

    localparam int   ITEMS_PER_PHASE = 125;
    localparam int   RAND_PHASES     = 7;
    localparam int   DRAIN_CYCLES    = 6;
    localparam int   LONG_HOLD       = 200;
    localparam int   GAP_MAX         = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd200;
    localparam res_t NO_WORD         = '0;

    // Byte source for a directed row: literal value, CRC bytes taken from the
    // model's running CRC (value is an XOR mask), or a register write
    typedef enum logic [1:0] {
        ROW_BYTE   = 2'd0,
        ROW_CRC_LO = 2'd1,
        ROW_CRC_HI = 2'd2,
        ROW_CFG    = 2'd3
    } row_op_t;

    typedef struct packed {
        row_op_t              op;
        logic [BYTE_W-1:0]    val;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic                 has_exp;
        res_t                 exp_w;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic                 kind;
    logic [BYTE_W-1:0]    data_byte;
    logic [BYTE_W-1:0]    byte_index;
    logic [1:0]           status;
    logic                 was_write;

    // Typed expectation travelling with the byte on the input side
    logic                 cur_has_exp;
    res_t                 cur_exp;

    // Framer model: registers and frame state
    logic [BYTE_W-1:0]    addr_reg    = SLAVE_ADDRESS_RST;
    logic [BYTE_W-1:0]    rd_fn_reg   = READ_FUNCTION_RST;
    logic [BYTE_W-1:0]    wr_fn_reg   = WRITE_FUNCTION_RST;
    logic                 wr_mode_reg = WRITE_MODE_RST;
    phase_t               fr_phase    = PH_HUNT;
    logic [BYTE_W-1:0]    fr_len      = '0;
    logic [BYTE_W-1:0]    fr_seen     = '0;
    logic [CRC_W-1:0]     frame_crc   = 16'hFFFF;
    logic [BYTE_W-1:0]    fr_crc_lo   = '0;

    res_t                 pending_words[$];
    int                   mismatches    = 0;
    int                   item_count    = 0;
    int                   tx_gap_max    = GAP_MAX;
    int                   rx_gap_max    = GAP_MAX;
    bit                   hold_long_req = 1'b0;

    modbus_rtu_response_framer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .status     (status),
        .was_write  (was_write)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Reflected CRC-16 over one byte, LSB first
    function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] c,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        return r;
    endfunction

    // Advance the framer model by one received byte
    task automatic frame_decode_byte(input logic [BYTE_W-1:0] b, output bit made,
                                     output res_t w);
        made = 1'b0;
        w    = NO_WORD;
        case (fr_phase)
            PH_FUNC:
            begin
                fr_phase = PH_HUNT;
                if (wr_mode_reg)
                begin
                    made        = 1'b1;
                    w.kind      = KIND_STATUS;
                    w.data_byte = b;
                    w.was_write = 1'b1;
                    if (b == wr_fn_reg)
                        w.status = ST_OK;
                    else if (b == (wr_fn_reg | EXC_BIT))
                        w.status = ST_EXCEPTION;
                    else
                        w.status = ST_MISMATCH;
                end
                else if (b == rd_fn_reg)
                begin
                    frame_crc = crc16_fold(frame_crc, b);
                    fr_phase  = PH_LEN;
                end
                else
                begin
                    made        = 1'b1;
                    w.kind      = KIND_STATUS;
                    w.data_byte = b;
                    w.status    = (b == (rd_fn_reg | EXC_BIT)) ? ST_EXCEPTION : ST_MISMATCH;
                end
            end
            PH_LEN:
            begin
                frame_crc = crc16_fold(frame_crc, b);
                fr_len    = b;
                fr_seen   = '0;
                fr_phase  = (b == 8'h00) ? PH_CRC_LO : PH_DATA;
            end
            PH_DATA:
            begin
                made         = 1'b1;
                w.kind       = KIND_DATA;
                w.data_byte  = b;
                w.byte_index = fr_seen;
                frame_crc    = crc16_fold(frame_crc, b);
                fr_seen      = fr_seen + 8'd1;
                if (fr_seen == fr_len)
                    fr_phase = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                fr_crc_lo = b;
                fr_phase  = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                made        = 1'b1;
                w.kind      = KIND_STATUS;
                w.data_byte = rd_fn_reg;
                w.status    = ({b, fr_crc_lo} == frame_crc) ? ST_OK : ST_CRC_ERR;
                fr_phase    = PH_HUNT;
            end
            default:
            begin
                fr_phase = PH_HUNT;
                if (b == addr_reg)
                begin
                    frame_crc = crc16_fold(16'hFFFF, b);
                    fr_phase  = PH_FUNC;
                end
            end
        endcase
    endtask

    // Track register writes and input bytes, check output words in order
    always @(posedge clk)
    begin : scoreboard
        res_t want;
        res_t seen;
        bit   made;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_SLAVE_ADDRESS:  addr_reg    = cfg_data;
                    CFG_READ_FUNCTION:  rd_fn_reg   = cfg_data;
                    CFG_WRITE_FUNCTION: wr_fn_reg   = cfg_data;
                    CFG_WRITE_MODE:     wr_mode_reg = cfg_data[0];
                    default: ;
                endcase
            if (in_valid && in_ready)
            begin
                frame_decode_byte(rx_byte, made, want);
                if (cur_has_exp)
                    pending_words.push_back(cur_exp);
                else if (made)
                    pending_words.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                seen = {kind, data_byte, byte_index, status, was_write};
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: expected no word, got kind %0d data %02h index %0d status %0d",
                             $time, kind, data_byte, byte_index, status);
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (seen.kind !== want.kind)
                    begin
                        mismatches++;
                        $display("%0t: kind expected %0d, got %0d",
                                 $time, want.kind, seen.kind);
                    end
                    if (seen.data_byte !== want.data_byte)
                    begin
                        mismatches++;
                        $display("%0t: data_byte expected %02h, got %02h",
                                 $time, want.data_byte, seen.data_byte);
                    end
                    if (seen.byte_index !== want.byte_index)
                    begin
                        mismatches++;
                        $display("%0t: byte_index expected %0d, got %0d",
                                 $time, want.byte_index, seen.byte_index);
                    end
                    if (seen.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, seen.status);
                    end
                    if (seen.was_write !== want.was_write)
                    begin
                        mismatches++;
                        $display("%0t: was_write expected %0d, got %0d",
                                 $time, want.was_write, seen.was_write);
                    end
                end
            end
        end
    end

    // Output side: random back-pressure per word, one long hold on request
    initial
    begin : result_sink
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long_req)
            begin
                gap           = LONG_HOLD;
                hold_long_req = 1'b0;
            end
            else
                gap = $urandom_range(rx_gap_max, 0);
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_byte(input row_op_t op, input logic [BYTE_W-1:0] val,
                             input bit has_exp, input res_t exp_w);
        int                gap;
        logic [BYTE_W-1:0] b;
        gap = $urandom_range(tx_gap_max, 0);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        // CRC bytes follow the model's running CRC, optionally corrupted
        case (op)
            ROW_CRC_LO: b = frame_crc[7:0] ^ val;
            ROW_CRC_HI: b = frame_crc[15:8] ^ val;
            default:    b = val;
        endcase
        in_valid    <= 1'b1;
        rx_byte     <= b;
        cur_has_exp <= has_exp;
        cur_exp     <= exp_w;
        item_count++;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected word, then let the pipeline drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One response frame with random content; plen_force >= 0 gives a clean
    // frame, in read mode a read frame of that payload length
    task automatic send_frame(input int plen_force);
        int                plen;
        int                fsel;
        logic [BYTE_W-1:0] fn;
        logic [BYTE_W-1:0] fn_ok;
        logic [BYTE_W-1:0] mask_lo;
        logic [BYTE_W-1:0] mask_hi;
        if (plen_force < 0 && $urandom_range(99, 0) < 8)
        begin
            repeat ($urandom_range(4, 1))
                send_byte(ROW_BYTE, 8'($urandom_range(255, 0)), 1'b0, NO_WORD);
            return;
        end
        send_byte(ROW_BYTE, addr_reg, 1'b0, NO_WORD);
        fn_ok = wr_mode_reg ? wr_fn_reg : rd_fn_reg;
        fsel  = (plen_force >= 0) ? 0 : $urandom_range(9, 0);
        if (fsel < 7)
            fn = fn_ok;
        else if (fsel < 9)
            fn = fn_ok | EXC_BIT;
        else
            fn = 8'($urandom_range(255, 0));
        send_byte(ROW_BYTE, fn, 1'b0, NO_WORD);
        if (wr_mode_reg || fn != rd_fn_reg)
            return;
        if (plen_force >= 0)
            plen = plen_force;
        else if ($urandom_range(39, 0) == 0)
            plen = $urandom_range(255, 13);
        else
            plen = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(12, 1);
        send_byte(ROW_BYTE, 8'(plen), 1'b0, NO_WORD);
        for (int i = 0; i < plen; i++)
        begin
            if ($urandom_range(3, 0) == 0)
                send_byte(ROW_BYTE, $urandom_range(1, 0) ? 8'hFF : 8'h00, 1'b0, NO_WORD);
            else
                send_byte(ROW_BYTE, 8'($urandom_range(255, 0)), 1'b0, NO_WORD);
        end
        // Cut the odd frame short before its CRC
        if (plen_force < 0 && $urandom_range(19, 0) == 0)
            return;
        mask_lo = ($urandom_range(11, 0) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
        mask_hi = ($urandom_range(11, 0) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
        if (plen_force >= 0)
        begin
            mask_lo = 8'h00;
            mask_hi = 8'h00;
        end
        send_byte(ROW_CRC_LO, mask_lo, 1'b0, NO_WORD);
        send_byte(ROW_CRC_HI, mask_hi, 1'b0, NO_WORD);
    endtask

    initial
    begin : stimulus
        dir_row_t rows[$];
        int       base;
        bit       paused;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        cur_has_exp = 1'b0;
        cur_exp     = NO_WORD;
        paused      = 1'b0;

        // Reset registers: address 1, read 3, write 6, read mode
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'hFF, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h83, 8'h00, 1'b1,
                                  res_t'{KIND_STATUS, 8'h83, 8'h00, ST_EXCEPTION, 1'b0}});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h10, 8'h00, 1'b1,
                                  res_t'{KIND_STATUS, 8'h10, 8'h00, ST_MISMATCH, 1'b0}});
        // Zero-length payload, clean CRC
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h03, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h00, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_CRC_LO, 8'h00, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_CRC_HI, 8'h00, 8'h00, 1'b1,
                                  res_t'{KIND_STATUS, 8'h03, 8'h00, ST_OK, 1'b0}});
        // Two payload bytes, then a corrupted CRC high byte
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h03, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h02, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h00, 8'h00, 1'b1,
                                  res_t'{KIND_DATA, 8'h00, 8'h00, ST_OK, 1'b0}});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'hFF, 8'h00, 1'b1,
                                  res_t'{KIND_DATA, 8'hFF, 8'h01, ST_OK, 1'b0}});
        rows.push_back(dir_row_t'{ROW_CRC_LO, 8'h00, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_CRC_HI, 8'hFF, 8'h00, 1'b1,
                                  res_t'{KIND_STATUS, 8'h03, 8'h00, ST_CRC_ERR, 1'b0}});
        // Write responses: ok, exception, mismatch
        rows.push_back(dir_row_t'{ROW_CFG, 8'h01, CFG_WRITE_MODE, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h06, 8'h00, 1'b1,
                                  res_t'{KIND_STATUS, 8'h06, 8'h00, ST_OK, 1'b1}});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h86, 8'h00, 1'b1,
                                  res_t'{KIND_STATUS, 8'h86, 8'h00, ST_EXCEPTION, 1'b1}});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h01, 8'h00, 1'b0, NO_WORD});
        rows.push_back(dir_row_t'{ROW_BYTE, 8'h03, 8'h00, 1'b1,
                                  res_t'{KIND_STATUS, 8'h03, 8'h00, ST_MISMATCH, 1'b1}});
        // Write to an index past the register map: no effect
        rows.push_back(dir_row_t'{ROW_CFG, 8'h55, CFG_IDX_SPARE, 1'b0, NO_WORD});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].op == ROW_CFG)
            begin
                settle();
                cfg_write(rows[i].reg_idx, rows[i].val);
            end
            else
                send_byte(rows[i].op, rows[i].val, rows[i].has_exp, rows[i].exp_w);
        end

        for (int k = 0; k < RAND_PHASES; k++)
        begin
            settle();
            cfg_write(CFG_SLAVE_ADDRESS, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF :
                                         8'($urandom_range(255, 0)));
            cfg_write(CFG_READ_FUNCTION, (k == 0) ? 8'hFF : (k == 2) ? 8'h00 :
                                         8'($urandom_range(255, 0)));
            cfg_write(CFG_WRITE_FUNCTION, (k == 1) ? 8'hFF : (k == 4) ? 8'h00 :
                                          8'($urandom_range(255, 0)));
            cfg_write(CFG_WRITE_MODE, (k % 3 == 1) ? 8'h01 : 8'h00);
            tx_gap_max = (k == 2 || k == 5) ? 0 : GAP_MAX;
            rx_gap_max = (k >= 5) ? 0 : GAP_MAX;
            // Stall the output for a long stretch while bytes keep coming
            if (k == 2)
                hold_long_req = 1'b1;
            base = item_count;
            while (item_count - base < ITEMS_PER_PHASE)
            begin
                if (k == 3 && !paused && item_count - base >= ITEMS_PER_PHASE / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
                send_frame((k == 0 && item_count == base) ? 255 : -1);
            end
        end

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
